[rtl/srm_pkg.sv]
// Shared constants and types for the sliding-window rate meter.
// Used by srm_cell, srm_div, the top level and the checker; no dependencies.
`default_nettype none

package srm_pkg;

  // Window geometry
  localparam int unsigned DEPTH  = 8;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned FILL_W = $clog2(DEPTH + 1);

  // Field widths
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned BYTE_W     = 48;
  localparam int unsigned INTERVAL_W = 16;
  localparam int unsigned MS_W       = 10;
  localparam int unsigned PROD_W     = BYTE_W + MS_W;
  localparam int unsigned DIV_CNT_W  = $clog2(PROD_W + 1);

  // Stream widths, padded to whole bytes
  localparam int unsigned IN_DATA_W  = ((TIME_W + BYTE_W + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W = ((BYTE_W + 7) / 8) * 8;

  // Constants
  localparam logic [INTERVAL_W-1:0] MIN_INTERVAL_RESET = INTERVAL_W'(900);
  localparam logic [MS_W-1:0]       MS_PER_S           = MS_W'(1000);
  localparam logic [BYTE_W-1:0]     SPEED_MAX          = '1;

  // Input kinds carried in tuser
  localparam logic OP_RESTART = 1'b0;
  localparam logic OP_SAMPLE  = 1'b1;

  // One window entry
  typedef struct packed {
    logic [TIME_W-1:0] t;
    logic [BYTE_W-1:0] b;
  } sample_t;

  // Per-cell command: load has priority over shift
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage

`default_nettype wire

[rtl/srm_cell.sv]
// One window cell: holds a (time, bytes) sample, loads new data or takes
// its upper neighbor's sample on a shift. Depends on srm_pkg.
`default_nettype none

module srm_cell (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  srm_pkg::cell_ctrl_t ctrl_i,
  input  srm_pkg::sample_t    load_i,
  input  srm_pkg::sample_t    next_i,
  output srm_pkg::sample_t    sample_o
);

  srm_pkg::sample_t sample_q, sample_d;

  // Load wins over shift
  always_comb begin
    sample_d = sample_q;
    if (ctrl_i.load) begin
      sample_d = load_i;
    end else if (ctrl_i.shift) begin
      sample_d = next_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q <= '0;
    end else begin
      sample_q <= sample_d;
    end
  end

  assign sample_o = sample_q;

endmodule

`default_nettype wire

[rtl/srm_div.sv]
// Restoring radix-2 divider, one quotient bit per cycle.
// Divides the scaled byte delta by the time span. Depends on srm_pkg.
`default_nettype none

module srm_div (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              start_i,
  input  wire [srm_pkg::PROD_W-1:0]        dividend_i,
  input  wire [srm_pkg::TIME_W-1:0]        divisor_i,
  output logic                             done_o,
  output logic [srm_pkg::PROD_W-1:0]       quotient_o
);

  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [srm_pkg::DIV_CNT_W-1:0]  cnt_q, cnt_d;
  logic [srm_pkg::TIME_W-1:0]     rem_q, rem_d;
  logic [srm_pkg::TIME_W-1:0]     dvs_q, dvs_d;
  logic [srm_pkg::PROD_W-1:0]     quo_q, quo_d;
  logic [srm_pkg::TIME_W:0]       rem_sh;
  logic [srm_pkg::TIME_W:0]       rem_sub;
  logic                           fits;

  // One trial subtraction
  assign rem_sh  = {rem_q, quo_q[srm_pkg::PROD_W-1]};
  assign fits    = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = srm_pkg::DIV_CNT_W'(srm_pkg::PROD_W);
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = fits ? rem_sub[srm_pkg::TIME_W-1:0] : rem_sh[srm_pkg::TIME_W-1:0];
      quo_d = {quo_q[srm_pkg::PROD_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == srm_pkg::DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

[rtl/sliding_window_rate_meter.sv]
// Top level of the sliding-window rate meter: window cell row, divider, control.
// Depends on srm_pkg, srm_cell and srm_div.
//
// Usage:
//   Input beats arrive on s_axis_*. tuser is the kind (0 restart, 1 sample);
//   tdata carries elapsed_ms in bits [31:0] and byte_count in bits [79:32].
//   A restart or a sample that comes too early (or with time going back)
//   is absorbed without leaving idle and gives no result beat.
//   An accepted sample yields one beat on m_axis_* with the speed in bytes
//   per second in tdata[47:0], saturated at 2^48-1.
//   An accepted sample passes through the multiply, divide and done states; the
//   divide state runs the 58-step bit-serial divider, which a zero time span or
//   zero byte growth skips. The next beat is taken once the control is idle again.
//   s_axis_tready is high whenever the control is idle, also while a
//   finished result waits in the output register.
//   A stalled receiver holds the result; a second result then waits in the
//   final control step until the output register frees up.
//   The user must write min_interval_ms through cfg_we_i / cfg_wdata_i only while
//   idle; the block does not enforce it. Reset empties the window, clears the last
//   sample time and sets the interval to 900 ms; output comes out of reset empty.
`default_nettype none

module sliding_window_rate_meter (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  // Configuration
  input  wire                                 cfg_we_i,
  input  wire [srm_pkg::INTERVAL_W-1:0]       cfg_wdata_i,     // min_interval_ms
  // Input stream
  input  wire                                 s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire [srm_pkg::IN_DATA_W-1:0]        s_axis_tdata,    // elapsed_ms, byte_count
  input  wire                                 s_axis_tuser,    // op
  // Output stream
  output logic                                m_axis_tvalid,
  input  wire                                 m_axis_tready,
  output logic [srm_pkg::OUT_DATA_W-1:0]      m_axis_tdata     // speed
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]                        state_q, state_d;
  logic [srm_pkg::FILL_W-1:0]        fill_q, fill_d;
  logic [srm_pkg::TIME_W-1:0]        last_q, last_d;
  logic [srm_pkg::INTERVAL_W-1:0]    min_q;
  logic                              out_valid_q, out_valid_d;
  logic [srm_pkg::BYTE_W-1:0]        out_data_q, out_data_d;

  logic [srm_pkg::TIME_W-1:0]        dt_q, dt_d;
  logic [srm_pkg::BYTE_W-1:0]        db_q, db_d;
  srm_pkg::sample_t                  new_q, new_d;
  logic [srm_pkg::PROD_W-1:0]        prod_q;
  logic                              zero_q, zero_d;
  logic                              div_start_q, div_start_d;
  logic                              div_done;
  logic [srm_pkg::PROD_W-1:0]        quotient;

  srm_pkg::sample_t                  cells [srm_pkg::DEPTH];
  srm_pkg::cell_ctrl_t               ctrl  [srm_pkg::DEPTH];
  srm_pkg::sample_t                  cell_load;

  logic                              accept;
  logic                              in_op;
  srm_pkg::sample_t                  in_smp;
  logic [srm_pkg::TIME_W:0]          gap;
  logic                              pass;
  logic                              full;
  logic                              empty;
  srm_pkg::sample_t                  oldest;
  logic [srm_pkg::BYTE_W-1:0]        speed;
  logic                              out_free;

  // Unpack the input beat
  assign in_op    = s_axis_tuser;
  assign in_smp.t = s_axis_tdata[srm_pkg::TIME_W-1:0];
  assign in_smp.b = s_axis_tdata[srm_pkg::TIME_W +: srm_pkg::BYTE_W];

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Sample gating: time must not go back and must clear the interval
  assign gap   = {1'b0, in_smp.t} - {1'b0, last_q};
  assign pass  = !gap[srm_pkg::TIME_W] &&
                 (gap[srm_pkg::TIME_W-1:0] >= srm_pkg::TIME_W'(min_q));
  assign full  = (fill_q == srm_pkg::FILL_W'(srm_pkg::DEPTH));
  assign empty = (fill_q == '0);

  // Oldest entry once the new sample is in
  assign oldest = full ? cells[1] : (empty ? in_smp : cells[0]);

  // Speed with saturation; a skipped division means zero
  assign speed = zero_q ? '0 :
                 (|quotient[srm_pkg::PROD_W-1:srm_pkg::BYTE_W]) ? srm_pkg::SPEED_MAX :
                 quotient[srm_pkg::BYTE_W-1:0];
  assign out_free = !out_valid_q || m_axis_tready;

  // Control and cell commands
  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    last_d      = last_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    dt_d        = dt_q;
    db_d        = db_q;
    new_d       = new_q;
    zero_d      = zero_q;
    div_start_d = 1'b0;
    cell_load   = in_smp;
    for (int i = 0; i < srm_pkg::DEPTH; i++) begin
      ctrl[i] = '0;
    end

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_op == srm_pkg::OP_RESTART) begin
            cell_load.t  = '0;
            ctrl[0].load = 1'b1;
            fill_d       = srm_pkg::FILL_W'(1);
            last_d       = '0;
          end else if (pass) begin
            last_d = in_smp.t;
            new_d  = in_smp;
            if (full) begin
              for (int i = 0; i < srm_pkg::DEPTH; i++) begin
                ctrl[i].shift = 1'b1;
              end
              ctrl[srm_pkg::DEPTH-1].load = 1'b1;
            end else begin
              for (int i = 0; i < srm_pkg::DEPTH; i++) begin
                ctrl[i].load = (fill_q == srm_pkg::FILL_W'(i));
              end
              fill_d = fill_q + 1'b1;
            end
            dt_d    = (in_smp.t > oldest.t) ? in_smp.t - oldest.t : '0;
            db_d    = (in_smp.b > oldest.b) ? in_smp.b - oldest.b : '0;
            state_d = S_MUL;
          end
        end
      end
      S_MUL: begin
        zero_d      = (dt_q == '0) || (db_q == '0);
        div_start_d = !((dt_q == '0) || (db_q == '0));
        state_d     = S_DIV;
      end
      S_DIV: begin
        if (zero_q || div_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = speed;
          // Zero speed collapses the window to the newest sample
          if (speed == '0) begin
            cell_load    = new_q;
            ctrl[0].load = 1'b1;
            fill_d       = srm_pkg::FILL_W'(1);
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      last_q      <= '0;
      min_q       <= srm_pkg::MIN_INTERVAL_RESET;
      out_valid_q <= 1'b0;
      zero_q      <= 1'b0;
      div_start_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
      zero_q      <= zero_d;
      div_start_q <= div_start_d;
      if (cfg_we_i) begin
        min_q <= cfg_wdata_i;
      end
    end
  end

  // Datapath registers; scaled byte delta registered before the divider
  always_ff @(posedge clk_i) begin
    dt_q       <= dt_d;
    db_q       <= db_d;
    new_q      <= new_d;
    out_data_q <= out_data_d;
    prod_q     <= srm_pkg::PROD_W'(db_q) * srm_pkg::PROD_W'(srm_pkg::MS_PER_S);
  end

  // Row of window cells, oldest in cell 0
  for (genvar g = 0; g < srm_pkg::DEPTH; g++) begin : g_cell
    srm_pkg::sample_t nbr;
    if (g == srm_pkg::DEPTH - 1) begin : g_last
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cells[g+1];
    end
    srm_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl[g]),
      .load_i   (cell_load),
      .next_i   (nbr),
      .sample_o (cells[g])
    );
  end

  srm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (prod_q),
    .divisor_i  (dt_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = srm_pkg::OUT_DATA_W'(out_data_q);

endmodule

`default_nettype wire

[rtl/srm_checker.sv]
// Port-level checker for the sliding-window rate meter, bound to the top level.
// Depends on srm_pkg and sliding_window_rate_meter.
`default_nettype none

module srm_checker (
  input wire                              clk_i,
  input wire                              rst_ni,
  input wire                              s_axis_tvalid,
  input wire                              s_axis_tready,
  input wire                              s_axis_tuser,
  input wire                              m_axis_tvalid,
  input wire                              m_axis_tready,
  input wire [srm_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // Output is empty once reset has been seen
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result valid during reset");

  // No result appears in the cycle right after an input beat
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result too early after input beat");

  // A restart is absorbed at once
  a_restart_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == srm_pkg::OP_RESTART)
    |=> s_axis_tready)
    else $error("input stalled after restart");

endmodule

bind sliding_window_rate_meter srm_checker u_srm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
